[hdl/sph_pkg.sv]
// Shared constants for the SPH poly6 / spiky kernel core.
// No dependencies; used by sph_mul_cell, sph_mul_chain and the core top level.
`timescale 1ns / 1ps

package sph_pkg;

  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned LIMB_W          = 32;

  localparam logic [31:0] RADIUS_RST = 32'd65536;
  localparam logic [63:0] POLY_RST   = 64'd6728845000;
  localparam logic [63:0] SPIKY_RST  = 64'd61520681851;
  localparam logic [15:0] EPS_RST    = 16'd7;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_POLY   = 2'd1,
    REG_SPIKY  = 2'd2,
    REG_EPS    = 2'd3
  } reg_idx_e;

endpackage

[hdl/sph_mul_cell.sv]
// One cell of a partial-product multiplier chain: adds one 32x32 limb product.
// Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_mul_cell #(
  parameter int unsigned AW    = 32,
  parameter int unsigned BW    = 32,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1,
  parameter int unsigned IA    = 0,
  parameter int unsigned IB    = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][AW-1:0]         a_i,
  input  logic [BW-1:0]                    b_i,
  input  logic [LANES-1:0][AW+BW-1:0]      acc_i,
  input  logic [SW-1:0]                    side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][AW-1:0]         a_o,
  output logic [BW-1:0]                    b_o,
  output logic [LANES-1:0][AW+BW-1:0]      acc_o,
  output logic [SW-1:0]                    side_o
);

  localparam int unsigned LW = sph_pkg::LIMB_W;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned SH = LW * (IA + IB);

  logic [LANES-1:0][2*LW-1:0] prod;
  logic [LANES-1:0][PW-1:0]   acc_d;
  logic                       valid_q;
  logic [LANES-1:0][AW-1:0]   a_q;
  logic [BW-1:0]              b_q;
  logic [LANES-1:0][PW-1:0]   acc_q;
  logic [SW-1:0]              side_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l]  = a_i[l][IA*LW +: LW] * b_i[IB*LW +: LW];
      acc_d[l] = acc_i[l] + (PW'(prod[l]) << SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

[hdl/sph_mul_chain.sv]
// Wide multiplier built as a row of limb cells, one partial product per cell.
// Depends on sph_pkg and sph_mul_cell.
`timescale 1ns / 1ps

module sph_mul_chain #(
  parameter int unsigned AW    = 32,
  parameter int unsigned BW    = 32,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][AW-1:0]    a_i,
  input  logic [BW-1:0]               b_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][AW+BW-1:0] p_o,
  output logic [SW-1:0]               side_o
);

  localparam int unsigned NA = AW / sph_pkg::LIMB_W;
  localparam int unsigned NB = BW / sph_pkg::LIMB_W;
  localparam int unsigned NC = NA * NB;

  logic [NC:0]                        v_s;
  logic [NC:0][LANES-1:0][AW-1:0]     a_s;
  logic [NC:0][BW-1:0]                b_s;
  logic [NC:0][LANES-1:0][AW+BW-1:0]  acc_s;
  logic [NC:0][SW-1:0]                side_s;

  assign v_s[0]    = valid_i;
  assign a_s[0]    = a_i;
  assign b_s[0]    = b_i;
  assign acc_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    sph_mul_cell #(
      .AW(AW), .BW(BW), .LANES(LANES), .SW(SW), .IA(k / NB), .IB(k % NB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(v_s[k]),
      .a_i    (a_s[k]),
      .b_i    (b_s[k]),
      .acc_i  (acc_s[k]),
      .side_i (side_s[k]),
      .valid_o(v_s[k+1]),
      .a_o    (a_s[k+1]),
      .b_o    (b_s[k+1]),
      .acc_o  (acc_s[k+1]),
      .side_o (side_s[k+1])
    );
  end

  assign valid_o = v_s[NC];
  assign p_o     = acc_s[NC];
  assign side_o  = side_s[NC];

endmodule

[hdl/sph_sqrt_cell.sv]
// One digit cell of the integer square root row: resolves root bit K.
// No package dependency.
`timescale 1ns / 1ps

module sph_sqrt_cell #(
  parameter int unsigned K  = 31,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   val_i,
  input  logic [34:0]   rem_i,
  input  logic [31:0]   root_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [63:0]   val_o,
  output logic [34:0]   rem_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  logic [34:0]   rem_sh;
  logic [34:0]   trial;
  logic          ge;
  logic          valid_q;
  logic [63:0]   val_q;
  logic [34:0]   rem_q;
  logic [31:0]   root_q;
  logic [SW-1:0] side_q;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_i[32:0], val_i[2*K+1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_i;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_i[30:0], ge};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

[hdl/sph_div_cell.sv]
// One cell of the restoring divider row: resolves quotient bit K for three lanes.
// No package dependency.
`timescale 1ns / 1ps

module sph_div_cell #(
  parameter int unsigned NW = 160,
  parameter int unsigned DW = 65,
  parameter int unsigned K  = 63,
  parameter int unsigned SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][NW-1:0]   rem_i,
  input  logic [DW-1:0]        dvs_i,
  input  logic [2:0][63:0]     quo_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [2:0][NW-1:0]   rem_o,
  output logic [DW-1:0]        dvs_o,
  output logic [2:0][63:0]     quo_o,
  output logic [SW-1:0]        side_o
);

  logic [NW-1:0]         dsh;
  logic [2:0]            ge;
  logic [2:0][NW-1:0]    rem_d;
  logic [2:0][63:0]      quo_d;
  logic                  valid_q;
  logic [2:0][NW-1:0]    rem_q;
  logic [DW-1:0]         dvs_q;
  logic [2:0][63:0]      quo_q;
  logic [SW-1:0]         side_q;

  assign dsh = NW'(dvs_i) << K;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ge[l]    = rem_i[l] >= dsh;
      rem_d[l] = ge[l] ? (rem_i[l] - dsh) : rem_i[l];
      quo_d[l] = {quo_i[l][62:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

[hdl/sph_poly6_spiky_kernel_core.sv]
// Top level of the SPH poly6 weight / spiky gradient kernel core.
// Depends on sph_pkg, sph_mul_chain, sph_sqrt_cell and sph_div_cell.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata: dx, dy, dz (32 b each)
//  m_      | out | m_tvalid/m_tready | tdata: weight, grad_x, grad_y, grad_z; tuser: in_range
//  apb     | in  | psel/penable      | radius @0x00, poly_coeff @0x08, spiky @0x10, eps @0x18
//
// One item per cycle while the skid register is empty; 137 register stages.
// The stage count is set by the 64-cell divider row, the 32-cell square root row and
// the limb multiplier rows (24 cells for the weight, 9 for the gradient).
// Reset clears all valid bits and loads the register defaults.
// A full skid register stalls the whole pipe and drops s_tready.
`timescale 1ns / 1ps

module sph_poly6_spiky_kernel_core #(
  parameter int unsigned FRAC_BITS = sph_pkg::COORD_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [95:0]  s_tdata_i,   // dx[31:0], dy[63:32], dz[95:64]
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [255:0] m_tdata_o,   // weight[63:0], grad_x, grad_y, grad_z[255:192]
  output logic [0:0]   m_tuser_o,   // in_range[0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned DW = 33 + 2 * FRAC_BITS;
  localparam int unsigned NW = 160;
  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             in_range;
    logic [63:0]      d2;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic [63:0] diff;
  } wsq_side_t;

  typedef struct packed {
    geo_t        geo;
    logic [63:0] weight;
  } root_side_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             in_range;
    logic [63:0]      weight;
    logic [32:0]      den;
  } grad_side_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic        in_range;
    logic [63:0] weight;
    logic [32:0] den;
  } gm_side_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic        in_range;
    logic [63:0] weight;
    logic        zero_den;
    logic [2:0]  ovf;
  } div_side_t;

  // ---------------- configuration ----------------
  logic [31:0] radius_q;
  logic [63:0] poly_q;
  logic [63:0] spiky_q;
  logic [15:0] eps_q;
  logic        cfg_wr;
  sph_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = sph_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sph_pkg::RADIUS_RST;
      poly_q   <= sph_pkg::POLY_RST;
      spiky_q  <= sph_pkg::SPIKY_RST;
      eps_q    <= sph_pkg::EPS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sph_pkg::REG_RADIUS: radius_q <= pwdata[31:0];
        sph_pkg::REG_POLY:   poly_q   <= pwdata;
        sph_pkg::REG_SPIKY:  spiky_q  <= pwdata;
        sph_pkg::REG_EPS:    eps_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sph_pkg::REG_RADIUS: prdata = {32'd0, radius_q};
      sph_pkg::REG_POLY:   prdata = poly_q;
      sph_pkg::REG_SPIKY:  prdata = spiky_q;
      sph_pkg::REG_EPS:    prdata = {48'd0, eps_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------- stall control ----------------
  logic en;
  logic skid_valid_q;

  assign en         = ~skid_valid_q;
  assign s_tready_o = en;

  // ---------------- front stages: squares, distance, range ----------------
  logic [2:0][31:0] in_c;
  logic [2:0][31:0] mag_c;
  logic [2:0]       neg_c;
  logic [2:0][63:0] sq_c;
  logic [63:0]      h2_q;

  logic             s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;
  logic [2:0]       s0_neg_q, s1_neg_q, s2_neg_q;
  logic [2:0][31:0] s0_mag_q, s1_mag_q, s2_mag_q;
  logic [2:0][63:0] s1_sq_q;
  logic [63:0]      s2_d2_q;
  geo_t             s3_geo_q;
  logic [63:0]      s3_diff_q;
  logic             in_rng_c;

  assign in_c = s_tdata_i;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      neg_c[l] = in_c[l][31];
      mag_c[l] = neg_c[l] ? (~in_c[l] + 32'd1) : in_c[l];
      sq_c[l]  = s0_mag_q[l] * s0_mag_q[l];
    end
  end

  assign in_rng_c = s2_d2_q <= h2_q;

  // the user must keep radius static while items are in flight; the core does not enforce it
  always_ff @(posedge clk_i) begin
    h2_q <= 64'(radius_q) * 64'(radius_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_tvalid_i;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_neg_q          <= neg_c;
      s0_mag_q          <= mag_c;
      s1_neg_q          <= s0_neg_q;
      s1_mag_q          <= s0_mag_q;
      s1_sq_q           <= sq_c;
      s2_neg_q          <= s1_neg_q;
      s2_mag_q          <= s1_mag_q;
      s2_d2_q           <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      s3_geo_q.neg      <= s2_neg_q;
      s3_geo_q.mag      <= s2_mag_q;
      s3_geo_q.in_range <= in_rng_c;
      s3_geo_q.d2       <= s2_d2_q;
      // zero difference makes the weight zero out of range
      s3_diff_q         <= in_rng_c ? (h2_q - s2_d2_q) : 64'd0;
    end
  end

  // ---------------- poly6 weight: diff^3 * poly_coeff ----------------
  wsq_side_t     w1_side_in;
  logic          w1_valid, w2_valid, w3_valid;
  logic [127:0]  w1_p;
  logic [191:0]  w2_p;
  logic [255:0]  w3_p;
  logic [$bits(wsq_side_t)-1:0] w1_side;
  logic [$bits(geo_t)-1:0]      w2_side, w3_side;
  wsq_side_t     w1_s;
  logic [255:0]  w_sh;
  logic          w_sat;
  logic          ws_valid_q;
  root_side_t    ws_q;

  assign w1_side_in.geo  = s3_geo_q;
  assign w1_side_in.diff = s3_diff_q;
  assign w1_s            = wsq_side_t'(w1_side);

  sph_mul_chain #(.AW(64), .BW(64), .LANES(1), .SW($bits(wsq_side_t))) u_wsq (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(s3_valid_q), .a_i(s3_diff_q), .b_i(s3_diff_q), .side_i(w1_side_in),
    .valid_o(w1_valid), .p_o(w1_p), .side_o(w1_side)
  );

  sph_mul_chain #(.AW(128), .BW(64), .LANES(1), .SW($bits(geo_t))) u_wcube (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(w1_valid), .a_i(w1_p), .b_i(w1_s.diff), .side_i(w1_s.geo),
    .valid_o(w2_valid), .p_o(w2_p), .side_o(w2_side)
  );

  sph_mul_chain #(.AW(192), .BW(64), .LANES(1), .SW($bits(geo_t))) u_wpoly (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(w2_valid), .a_i(w2_p), .b_i(poly_q), .side_i(w2_side),
    .valid_o(w3_valid), .p_o(w3_p), .side_o(w3_side)
  );

  assign w_sh  = w3_p >> (6 * FRAC_BITS);
  assign w_sat = |w_sh[255:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_valid_q <= 1'b0;
    end else if (en) begin
      ws_valid_q <= w3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ws_q.geo    <= geo_t'(w3_side);
      ws_q.weight <= w_sat ? '1 : w_sh[63:0];
    end
  end

  // ---------------- norm: 32-cell square root row ----------------
  logic [32:0]                           sq_v;
  logic [32:0][63:0]                     sq_val;
  logic [32:0][34:0]                     sq_rem;
  logic [32:0][31:0]                     sq_root;
  logic [32:0][$bits(root_side_t)-1:0]   sq_side;

  assign sq_v[0]    = ws_valid_q;
  assign sq_val[0]  = ws_q.geo.d2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = ws_q;

  for (genvar c = 0; c < 32; c++) begin : g_sqrt
    sph_sqrt_cell #(.K(31 - c), .SW($bits(root_side_t))) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(sq_v[c]), .val_i(sq_val[c]), .rem_i(sq_rem[c]),
      .root_i(sq_root[c]), .side_i(sq_side[c]),
      .valid_o(sq_v[c+1]), .val_o(sq_val[c+1]), .rem_o(sq_rem[c+1]),
      .root_o(sq_root[c+1]), .side_o(sq_side[c+1])
    );
  end

  root_side_t rt_s;
  logic       k_valid_q;
  logic [31:0] hn_q;
  grad_side_t gs_q;

  assign rt_s = root_side_t'(sq_side[32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_valid_q <= 1'b0;
    end else if (en) begin
      k_valid_q <= sq_v[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hn_q          <= radius_q - sq_root[32];
      gs_q.neg      <= rt_s.geo.neg;
      gs_q.mag      <= rt_s.geo.mag;
      gs_q.in_range <= rt_s.geo.in_range;
      gs_q.weight   <= rt_s.weight;
      gs_q.den      <= {1'b0, sq_root[32]} + {17'd0, eps_q};
    end
  end

  // ---------------- spiky numerator: (h-n)^2 * coeff * |r_i| ----------------
  logic          g1_valid, g2_valid, g3_valid;
  logic [63:0]   g1_p;
  logic [127:0]  g2_p;
  logic [2:0][NW-1:0] g3_p;
  logic [$bits(grad_side_t)-1:0] g1_side, g2_side;
  logic [$bits(gm_side_t)-1:0]   g3_side;
  grad_side_t    g2_s;
  gm_side_t      gm_in;
  gm_side_t      gm_s;

  sph_mul_chain #(.AW(32), .BW(32), .LANES(1), .SW($bits(grad_side_t))) u_hn2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(k_valid_q), .a_i(hn_q), .b_i(hn_q), .side_i(gs_q),
    .valid_o(g1_valid), .p_o(g1_p), .side_o(g1_side)
  );

  sph_mul_chain #(.AW(64), .BW(64), .LANES(1), .SW($bits(grad_side_t))) u_spk (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(g1_valid), .a_i(g1_p), .b_i(spiky_q), .side_i(g1_side),
    .valid_o(g2_valid), .p_o(g2_p), .side_o(g2_side)
  );

  assign g2_s           = grad_side_t'(g2_side);
  assign gm_in.neg      = g2_s.neg;
  assign gm_in.in_range = g2_s.in_range;
  assign gm_in.weight   = g2_s.weight;
  assign gm_in.den      = g2_s.den;

  sph_mul_chain #(.AW(32), .BW(128), .LANES(3), .SW($bits(gm_side_t))) u_mag (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .valid_i(g2_valid), .a_i(g2_s.mag), .b_i(g2_p), .side_i(gm_in),
    .valid_o(g3_valid), .p_o(g3_p), .side_o(g3_side)
  );

  assign gm_s = gm_side_t'(g3_side);

  // ---------------- divider setup: scaled divisor, overflow test ----------------
  logic [DW-1:0]      dvs_c;
  logic [2:0]         ovf_c;
  logic               v_valid_q;
  logic [2:0][NW-1:0] v_num_q;
  logic [DW-1:0]      v_dvs_q;
  div_side_t          v_side_q;

  assign dvs_c = DW'(gm_s.den) << (2 * FRAC_BITS);

  // quotient reaches 2^64 exactly when the upper numerator bits reach the divisor
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ovf_c[l] = g3_p[l][NW-1:64] >= (NW - 64)'(dvs_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
    end else if (en) begin
      v_valid_q <= g3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_num_q           <= g3_p;
      v_dvs_q           <= dvs_c;
      v_side_q.neg      <= gm_s.neg;
      v_side_q.in_range <= gm_s.in_range;
      v_side_q.weight   <= gm_s.weight;
      v_side_q.zero_den <= gm_s.den == 33'd0;
      v_side_q.ovf      <= ovf_c;
    end
  end

  // ---------------- 64-cell divider row ----------------
  logic [64:0]                          dv_v;
  logic [64:0][2:0][NW-1:0]             dv_rem;
  logic [64:0][DW-1:0]                  dv_dvs;
  logic [64:0][2:0][63:0]               dv_quo;
  logic [64:0][$bits(div_side_t)-1:0]   dv_side;

  assign dv_v[0]    = v_valid_q;
  assign dv_rem[0]  = v_num_q;
  assign dv_dvs[0]  = v_dvs_q;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = v_side_q;

  for (genvar c = 0; c < 64; c++) begin : g_div
    sph_div_cell #(.NW(NW), .DW(DW), .K(63 - c), .SW($bits(div_side_t))) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(dv_v[c]), .rem_i(dv_rem[c]), .dvs_i(dv_dvs[c]),
      .quo_i(dv_quo[c]), .side_i(dv_side[c]),
      .valid_o(dv_v[c+1]), .rem_o(dv_rem[c+1]), .dvs_o(dv_dvs[c+1]),
      .quo_o(dv_quo[c+1]), .side_o(dv_side[c+1])
    );
  end

  // ---------------- sign, saturation, result ----------------
  div_side_t        fin_s;
  logic [2:0][63:0] grad_c;
  logic [2:0][63:0] mneg_c;
  logic [255:0]     res_data;

  assign fin_s = div_side_t'(dv_side[64]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mneg_c[l] = (fin_s.ovf[l] || dv_quo[64][l] > NEG_LIM) ? NEG_LIM : dv_quo[64][l];
      if (!fin_s.in_range || fin_s.zero_den) begin
        grad_c[l] = '0;
      end else if (fin_s.neg[l]) begin
        grad_c[l] = (fin_s.ovf[l] || dv_quo[64][l] > POS_LIM) ? POS_LIM : dv_quo[64][l];
      end else begin
        grad_c[l] = ~mneg_c[l] + 64'd1;
      end
    end
  end

  assign res_data = {grad_c[2], grad_c[1], grad_c[0], fin_s.weight};

  // ---------------- output register and skid ----------------
  logic         out_valid_q;
  logic [255:0] out_data_q;
  logic         out_user_q;
  logic [255:0] skid_data_q;
  logic         skid_user_q;
  logic         out_take;
  logic         load_out;
  logic         load_skid;

  assign out_take  = out_valid_q & m_tready_i;
  assign load_out  = en & dv_v[64] & (~out_valid_q | out_take);
  assign load_skid = en & dv_v[64] & out_valid_q & ~out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (load_skid) begin
      skid_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q && out_take) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end else if (load_out) begin
      out_data_q <= res_data;
      out_user_q <= fin_s.in_range;
    end
    if (load_skid) begin
      skid_data_q <= res_data;
      skid_user_q <= fin_s.in_range;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(m_tvalid_o && !m_tready_i))
    else $error("skid filled without an output stall");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[0]) |-> (m_tdata_o == '0))
    else $error("out-of-range item carries nonzero weight or gradient");

endmodule

[tb/sph_poly6_spiky_kernel_core_test.sv]
// Self-checking testbench for sph_poly6_spiky_kernel_core: stream items in,
// predict weight / spiky gradient per item, compare every result in order.
// Depends on sph_pkg and the core RTL.
`timescale 1ns / 1ps

module sph_poly6_spiky_kernel_core_test;

  localparam int FB       = sph_pkg::COORD_FRAC_BITS;
  localparam int LIMIT    = 400000;
  localparam int LATENCY  = 137;
  localparam int HOLD_LEN = 600;

  typedef struct {
    logic [63:0] weight;
    logic [63:0] gx, gy, gz;
    logic        in_range;
  } kern_t;

  typedef struct {
    int          phase;
    logic [31:0] dx, dy, dz;
    bit          typed;
    kern_t       res;
  } stim_t;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_tvalid = 0;
  logic [95:0]  s_tdata = '0;
  logic         m_tready = 0;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic         s_tready_o, m_tvalid_o, pready;
  logic [255:0] m_tdata_o;
  logic [0:0]   m_tuser_o;
  logic [63:0]  prdata;

  // local copy of the register file
  logic [31:0] h_q;
  logic [63:0] poly_q, spiky_q;
  logic [15:0] eps_q;

  kern_t kern_expected[$];
  int    fails = 0;
  int    results_seen = 0;
  int    cycles = 0;
  bit    rx_hold = 0;

  sph_poly6_spiky_kernel_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready_o), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready), .m_tdata_o(m_tdata_o),
    .m_tuser_o(m_tuser_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sph_poly6_spiky_kernel_core: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] spiky_axis(logic [31:0] r, logic [63:0] hn2,
                                             logic [64:0] den);
    logic [255:0] num;
    logic [255:0] q;
    logic [31:0]  mag;
    logic [63:0]  m;
    bit           sat;
    mag = abs32(r);
    if (mag == 0 || den == 0) return 64'd0;
    num = 256'(hn2) * 256'(spiky_q) * 256'(mag);
    q = (num / 256'(den)) >> (2 * FB);
    sat = |q[255:64];
    m = q[63:0];
    // gradient points against the displacement
    if (r[31]) begin
      if (sat || m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      return m;
    end
    if (sat || m > 64'h8000_0000_0000_0000) m = 64'h8000_0000_0000_0000;
    return ~m + 64'd1;
  endfunction

  function automatic kern_t kernel_of(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    kern_t        k;
    logic [63:0]  d2, h2, diff, norm, hn;
    logic [255:0] w;
    logic [64:0]  den;
    d2 = 64'(abs32(dx)) * abs32(dx) + 64'(abs32(dy)) * abs32(dy)
       + 64'(abs32(dz)) * abs32(dz);
    h2 = 64'(h_q) * h_q;
    k = '{default: '0};
    if (d2 > h2) return k;
    diff = h2 - d2;
    w = (256'(diff) * 256'(diff) * 256'(diff) * 256'(poly_q)) >> (6 * FB);
    k.weight = (|w[255:64]) ? '1 : w[63:0];
    norm = floor_sqrt(d2);
    hn = 64'(h_q) - norm;
    den = 65'(norm) + eps_q;
    k.gx = spiky_axis(dx, hn * hn, den);
    k.gy = spiky_axis(dy, hn * hn, den);
    k.gz = spiky_axis(dz, hn * hn, den);
    k.in_range = 1'b1;
    return k;
  endfunction

  task automatic reg_write(sph_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      sph_pkg::REG_RADIUS: h_q = val[31:0];
      sph_pkg::REG_POLY:   poly_q = val;
      sph_pkg::REG_SPIKY:  spiky_q = val;
      sph_pkg::REG_EPS:    eps_q = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (kern_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
  endtask

  bit tx_burst = 0;

  task automatic send_item(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           bit typed, kern_t res);
    int gap;
    gap = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata <= {dz, dy, dx};
    do @(posedge clk_i); while (!s_tready_o);
    kern_expected.push_back(typed ? res : kernel_of(dx, dy, dz));
  endtask

  function automatic logic [31:0] signed_mag(logic [31:0] mag);
    return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
  endfunction

  // mostly displacements inside the radius, some at its rim, some noise
  task automatic send_random(int n);
    logic [31:0] lim, c[3];
    int          kind;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      lim = (h_q >> 1) > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : (h_q >> 1);
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 3; j++) begin
        if (kind < 7)      c[j] = signed_mag($urandom_range(0, lim));
        else if (kind < 8) c[j] = (j == 0) ? signed_mag((h_q > 32'h7FFF_FFFF) ?
                                  32'h7FFF_FFFF : h_q + $urandom_range(0, 1)) : 0;
        else               c[j] = $urandom;
      end
      send_item(c[0], c[1], c[2], 0, '{default: '0});
    end
    s_tvalid <= 0;
  endtask

  // result side: random stalls, plus one long hold so the pipe backs up
  int  rx_wait = 0;
  int  rx_hold_cnt = 0;
  bit  rx_burst = 0;
  always @(posedge clk_i) begin
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      m_tready <= (rx_hold_cnt == 1);
      if (rx_hold_cnt == 1) rx_hold <= 0;
    end else if (m_tvalid_o && m_tready) begin
      kern_t e, a;
      int    w;
      a.weight = m_tdata_o[63:0];
      a.gx = m_tdata_o[127:64];
      a.gy = m_tdata_o[191:128];
      a.gz = m_tdata_o[255:192];
      a.in_range = m_tuser_o[0];
      if (kern_expected.size() == 0) begin
        $display("%0t: result with nothing expected: w=%h", $time, a.weight);
        fails++;
      end else begin
        e = kern_expected.pop_front();
        if (a.weight !== e.weight) begin
          $display("%0t: weight exp %h got %h", $time, e.weight, a.weight); fails++;
        end
        if (a.gx !== e.gx) begin
          $display("%0t: grad_x exp %h got %h", $time, e.gx, a.gx); fails++;
        end
        if (a.gy !== e.gy) begin
          $display("%0t: grad_y exp %h got %h", $time, e.gy, a.gy); fails++;
        end
        if (a.gz !== e.gz) begin
          $display("%0t: grad_z exp %h got %h", $time, e.gz, a.gz); fails++;
        end
        if (a.in_range !== e.in_range) begin
          $display("%0t: in_range exp %b got %b", $time, e.in_range, a.in_range); fails++;
        end
      end
      results_seen <= results_seen + 1;
      if (results_seen == 60) begin
        rx_hold_cnt <= HOLD_LEN;
        rx_hold <= 1;
        m_tready <= 0;
      end else begin
        if (results_seen % 50 == 0) rx_burst <= ($urandom_range(0, 3) == 0);
        w = rx_burst ? 0 : $urandom_range(0, 19);
        rx_wait <= w;
        m_tready <= (w == 0);
      end
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1;
    end
  end

  stim_t dir_rows[$];

  function automatic kern_t typed_res(logic [63:0] w, logic ir);
    kern_t k;
    k = '{default: '0};
    k.weight = w;
    k.in_range = ir;
    return k;
  endfunction

  task automatic add_row(int ph, logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         bit typed, kern_t res);
    dir_rows.push_back('{ph, dx, dy, dz, typed, res});
  endtask

  task automatic run_directed(int ph);
    foreach (dir_rows[i])
      if (dir_rows[i].phase == ph)
        send_item(dir_rows[i].dx, dir_rows[i].dy, dir_rows[i].dz,
                  dir_rows[i].typed, dir_rows[i].res);
    s_tvalid <= 0;
  endtask

  initial begin
    kern_t none;
    none = '{default: '0};
    h_q = sph_pkg::RADIUS_RST; poly_q = sph_pkg::POLY_RST;
    spiky_q = sph_pkg::SPIKY_RST; eps_q = sph_pkg::EPS_RST;

    // reset defaults
    add_row(0, 0, 0, 0, 1, typed_res(sph_pkg::POLY_RST, 1));
    add_row(0, 32'h8000_0000, 0, 0, 1, none);
    add_row(0, 0, 32'h7FFF_FFFF, 0, 1, none);
    add_row(0, 0, 0, 32'h8000_0000, 1, none);
    add_row(0, 32'h0001_0000, 0, 0, 0, none);          // exactly on the radius
    add_row(0, 32'h0001_0001, 0, 0, 1, none);          // just outside
    add_row(0, 32'hFFFF_0000, 0, 0, 0, none);
    add_row(0, 32'h0000_8000, 32'hFFFF_8000, 0, 0, none);
    add_row(0, 32'h0000_4000, 32'h0000_4000, 32'hFFFF_C000, 0, none);
    add_row(0, 1, 32'hFFFF_FFFF, 0, 0, none);
    add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none);
    add_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, none);
    // all registers at maximum, eps zero: saturation and the zero divisor
    add_row(1, 0, 0, 0, 1, typed_res('1, 1));
    add_row(1, 1, 0, 0, 0, none);
    add_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none);
    add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, none);
    add_row(1, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, none);
    // all registers at minimum, eps maximal
    add_row(2, 0, 0, 0, 1, typed_res(0, 1));
    add_row(2, 1, 0, 0, 1, none);
    add_row(2, 0, 32'hFFFF_FFFF, 0, 1, none);
    add_row(2, 0, 0, 32'h8000_0000, 1, none);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (5) @(posedge clk_i);

    run_directed(0);
    send_random(200);
    drain();

    reg_write(sph_pkg::REG_RADIUS, 64'hFFFF_FFFF);
    reg_write(sph_pkg::REG_POLY, '1);
    reg_write(sph_pkg::REG_SPIKY, '1);
    reg_write(sph_pkg::REG_EPS, 0);
    run_directed(1);
    send_random(100);
    drain();

    reg_write(sph_pkg::REG_RADIUS, 0);
    reg_write(sph_pkg::REG_POLY, 0);
    reg_write(sph_pkg::REG_SPIKY, 0);
    reg_write(sph_pkg::REG_EPS, 16'hFFFF);
    run_directed(2);
    send_random(40);
    drain();

    for (int p = 0; p < 3; p++) begin
      reg_write(sph_pkg::REG_RADIUS, $urandom_range(32'h0000_1000, 32'h0040_0000));
      reg_write(sph_pkg::REG_POLY, {$urandom, $urandom} >> $urandom_range(0, 63));
      reg_write(sph_pkg::REG_SPIKY, {$urandom, $urandom} >> $urandom_range(0, 63));
      reg_write(sph_pkg::REG_EPS, $urandom_range(0, 16'hFFFF));
      send_random(100);
      drain();
    end

    if (fails == 0) begin
      $display("sph_poly6_spiky_kernel_core: match");
    end else begin
      $display("sph_poly6_spiky_kernel_core: mismatch");
    end
    $finish;
  end

endmodule
